// ===== rtl/ilir_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the indexed list block.
// Used by the controller, the datapath and the top level; no dependencies.
package ilir_pkg;

  localparam int DEPTH_DEF     = 64;
  localparam int WORD_BITS_DEF = 32;
  localparam int POS_BITS      = 7;
  localparam int OUT_BITS      = 32;

  localparam logic [1:0] ACT_PUSH   = 2'd0;
  localparam logic [1:0] ACT_POP    = 2'd1;
  localparam logic [1:0] ACT_INSERT = 2'd2;
  localparam logic [1:0] ACT_REMOVE = 2'd3;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic        [1:0]          action;
    logic        [POS_BITS-1:0] position;
    logic signed [OUT_BITS-1:0] word_in;
  } ilir_item_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] front_value;
    logic signed [OUT_BITS-1:0] back_value;
    logic        [POS_BITS-1:0] count;
    logic                       is_empty;
    logic        [1:0]          status;
  } ilir_result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } ilir_cmd_t;

endpackage

// ===== rtl/ilir_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencing controller for the indexed list block.
// Depends on ilir_pkg for the command struct.
module ilir_ctrl import ilir_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  output logic      result_valid,
  input  logic      result_stall,
  output ilir_cmd_t cmd
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_LOAD} state_t;

  state_t state;
  logic   accept;
  logic   can_load;

  assign item_stall  = (state != S_IDLE);
  assign accept      = item_valid && !item_stall;
  assign can_load    = !result_valid || !result_stall;

  assign cmd.capture = accept;
  assign cmd.exec    = (state == S_EXEC);
  assign cmd.load    = (state == S_LOAD) && can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      // Raise valid on a result load; drop it once the result transfers.
      if (cmd.load) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (can_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_EXEC)
    else $error("accepted transfer did not start execution");

  a_exec_load: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC |=> state == S_LOAD)
    else $error("execution did not advance to result load");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> result_valid)
    else $error("result load did not raise result_valid");

endmodule

// ===== rtl/ilir_datapath.sv =====
`timescale 1ns / 1ps
// Register-chain storage, fill count, status and result register.
// Depends on ilir_pkg for item, result and command types and codes.
module ilir_datapath import ilir_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  ilir_cmd_t    cmd,
  input  ilir_item_t   item,
  output ilir_result_t result
);

  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int CMP_W  = (FILL_W > POS_BITS) ? FILL_W : POS_BITS;

  logic [1:0]           act;
  logic [CMP_W-1:0]     pos;
  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS-1:0] cells [DEPTH];
  logic [FILL_W-1:0]    fill;
  logic [1:0]           status;

  logic [CMP_W-1:0]     fill_c;
  logic                 is_ins;
  logic [CMP_W-1:0]     ipos;
  logic [CMP_W-1:0]     rpos;
  logic [1:0]           status_next;
  logic                 do_ins;
  logic                 do_rem;
  logic [WORD_BITS-1:0] back_sel;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act  <= item.action;
      pos  <= CMP_W'(item.position);
      word <= WORD_BITS'(unsigned'(item.word_in));
    end
  end

  always_comb begin
    fill_c = CMP_W'(fill);
    is_ins = (act == ACT_PUSH) || (act == ACT_INSERT);
    ipos   = (act == ACT_PUSH) ? fill_c : pos;
    rpos   = ((act == ACT_POP) || (pos >= fill_c)) ? fill_c - CMP_W'(1) : pos;
    if (is_ins) begin
      if (ipos > fill_c) begin
        status_next = ST_BAD_INDEX;
      end else if (fill_c >= CMP_W'(DEPTH)) begin
        status_next = ST_FULL;
      end else begin
        status_next = ST_DONE;
      end
    end else begin
      status_next = (fill == '0) ? ST_EMPTY : ST_DONE;
    end
    do_ins = is_ins && (status_next == ST_DONE);
    do_rem = !is_ins && (status_next == ST_DONE);
  end

  // Each cell loads the new word, takes its lower neighbor (insert) or its
  // upper neighbor (remove), or holds.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_BITS-1:0] below;
    logic [WORD_BITS-1:0] above;
    if (g == 0) begin : g_first
      assign below = word;
    end else begin : g_mid
      assign below = cells[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign above = cells[g];
    end else begin : g_inner
      assign above = cells[g+1];
    end
    always_ff @(posedge clk) begin
      if (cmd.exec) begin
        if (do_ins && (CMP_W'(g) == ipos)) begin
          cells[g] <= word;
        end else if (do_ins && (CMP_W'(g) > ipos)) begin
          cells[g] <= below;
        end else if (do_rem && (CMP_W'(g) >= rpos)) begin
          cells[g] <= above;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.exec) begin
      if (do_ins) begin
        fill <= fill + FILL_W'(1);
      end else if (do_rem) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status <= status_next;
    end
  end

  // One-hot pick of the last occupied cell.
  always_comb begin
    back_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (CMP_W'(i) == fill_c - CMP_W'(1)) begin
        back_sel = back_sel | cells[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      result.front_value <= (fill == '0) ? '0 : OUT_BITS'(cells[0]);
      result.back_value  <= (fill == '0) ? '0 : OUT_BITS'(back_sel);
      result.count       <= POS_BITS'(fill);
      result.is_empty    <= (fill == '0);
      result.status      <= status;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(fill) <= CMP_W'(DEPTH))
    else $error("fill count exceeds depth");

  a_fill_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.exec |=> $stable(fill))
    else $error("fill count changed outside execution");

  a_empty_remove: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && !is_ins && (fill == '0) |=> status == ST_EMPTY && fill == '0)
    else $error("remove on empty list not ignored");

endmodule

// ===== rtl/indexed_list_insert_remove_top.sv =====
`timescale 1ns / 1ps
// Top level of the indexed list block: controller plus register-chain datapath.
// Depends on ilir_pkg, ilir_ctrl and ilir_datapath.
//
//  channel | handshake                  | payload
//  --------+----------------------------+---------------------------------------
//  item    | item_valid / item_stall    | action, position, word_in
//  result  | result_valid / result_stall| front_value, back_value, count,
//          |                            | is_empty, status
//
// Each item is captured at its transfer; the execute state then shifts the
// whole register chain at once, and the load state loads the result register
// from the chain head and the last occupied cell. A stalled result holds in the
// result register and holds the load; the next item is taken once the
// controller returns to idle. Synchronous reset empties the list; cell contents
// are left as they are and are never read at or past the fill count.
module indexed_list_insert_remove_top import ilir_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  output logic         item_stall,
  input  ilir_item_t   item,
  output logic         result_valid,
  input  logic         result_stall,
  output ilir_result_t result
);

  // Commands from the sequencer to the storage datapath.
  ilir_cmd_t cmd;

  // Sequence capture, execute and load; own both handshakes.
  ilir_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd)
  );

  // Hold the list in a shifting register chain and build each result.
  ilir_datapath #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .item   (item),
    .result (result)
  );

endmodule

// ===== dv/tb_indexed_list_insert_remove_top.sv =====
`timescale 1ns / 1ps
// Testbench for indexed_list_insert_remove_top. It sends push, pop, insert and
// remove transfers and checks every result against a list model kept in the bench.
// Depends on ilir_pkg and the RTL of the block only.
module tb_indexed_list_insert_remove_top;
  import ilir_pkg::*;

  localparam int LIST_DEPTH   = DEPTH_DEF;
  localparam int MAX_POS      = (1 << POS_BITS) - 1;
  localparam int RANDOM_ITEMS = 1900;
  localparam int PHASE_LEN    = 100;
  // Margin after the last predicted summary has been checked.
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 120;

  typedef enum int {TREND_GROW, TREND_SHRINK, TREND_MIXED} list_trend_t;

  logic         clk          = 1'b0;
  logic         rst          = 1'b1;
  logic         item_valid   = 1'b0;
  logic         item_stall;
  ilir_item_t   item         = '0;
  logic         result_valid;
  logic         result_stall = 1'b0;
  ilir_result_t result;

  // Bench copy of the list, updated once per accepted transfer.
  logic signed [OUT_BITS-1:0] list_cells [LIST_DEPTH];
  int unsigned                list_fill = 0;

  // Summaries (front, back, count, flags) still to come out of the block.
  ilir_result_t predicted_summaries [$];
  ilir_result_t summary_due;
  int unsigned  mismatch_count = 0;

  // Idle controls shared by the test tasks and the result stall process.
  bit          sender_gaps_on     = 1'b0;
  bit          receiver_stalls_on = 1'b0;
  int unsigned stall_left         = 0;
  int unsigned long_hold_req      = 0;

  always #2 clk = ~clk;

  indexed_list_insert_remove_top #(
    .DEPTH    (LIST_DEPTH),
    .WORD_BITS(OUT_BITS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  // ---------------------------------------------------------------------------
  // List model
  // ---------------------------------------------------------------------------

  // Insert at an index: the index check comes ahead of the full check, and an
  // index equal to the count appends.
  function automatic logic [1:0] list_put(int unsigned at, logic signed [OUT_BITS-1:0] word);
    if (at > list_fill) return ST_BAD_INDEX;
    if (list_fill >= LIST_DEPTH) return ST_FULL;
    for (int unsigned i = list_fill; i > at; i--) list_cells[i] = list_cells[i - 1];
    list_cells[at] = word;
    list_fill++;
    return ST_DONE;
  endfunction

  // Remove at an index; an index at or past the count takes the last entry.
  function automatic logic [1:0] list_take(int unsigned at);
    int unsigned k;
    if (list_fill == 0) return ST_EMPTY;
    k = (at >= list_fill) ? list_fill - 1 : at;
    for (int unsigned i = k; i + 1 < list_fill; i++) list_cells[i] = list_cells[i + 1];
    list_fill--;
    return ST_DONE;
  endfunction

  // Apply one operation to the bench list and return the summary it yields.
  function automatic ilir_result_t apply_list_op(ilir_item_t it);
    ilir_result_t r;
    r = '0;
    case (it.action)
      ACT_PUSH:   r.status = list_put(list_fill, it.word_in);
      ACT_POP:    r.status = list_take(list_fill);
      ACT_INSERT: r.status = list_put(it.position, it.word_in);
      ACT_REMOVE: r.status = list_take(it.position);
    endcase
    if (list_fill != 0) begin
      r.front_value = list_cells[0];
      r.back_value  = list_cells[list_fill - 1];
    end
    r.count    = POS_BITS'(list_fill);
    r.is_empty = (list_fill == 0);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic ilir_item_t mk_item(logic [1:0] act, int unsigned pos,
                                         logic signed [OUT_BITS-1:0] word);
    ilir_item_t it;
    it.action   = act;
    it.position = POS_BITS'(pos);
    it.word_in  = word;
    return it;
  endfunction

  // Mostly no pause, often a short one, now and then a long one.
  function automatic int unsigned random_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Full-range words, with the sign extremes and all-ones mixed in.
  function automatic logic signed [OUT_BITS-1:0] random_word();
    case ($urandom_range(0, 19))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '1;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // Offer one item from a falling edge, hold it until the transfer, record the
  // prediction and return on the next falling edge.
  task automatic send_item(ilir_item_t it);
    int unsigned gap;
    gap = sender_gaps_on ? random_pause() : 0;
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predicted_summaries.push_back(apply_list_op(it));
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted summary has been checked.
  task automatic wait_drained();
    item_valid <= 1'b0;
    while (predicted_summaries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty list, bad indexes, append by index, middle and end removal.
  task automatic test_directed_edges();
    sender_gaps_on     = 1'b1;
    receiver_stalls_on = 1'b1;
    send_item(mk_item(ACT_POP,    0,       '0));
    send_item(mk_item(ACT_REMOVE, 0,       '0));
    send_item(mk_item(ACT_REMOVE, MAX_POS, '0));
    send_item(mk_item(ACT_INSERT, 1,       32'sh1234_5678));
    send_item(mk_item(ACT_INSERT, MAX_POS, 32'sh1234_5678));
    send_item(mk_item(ACT_PUSH,   MAX_POS, 32'sh7FFF_FFFF));
    send_item(mk_item(ACT_PUSH,   0,       32'sh8000_0000));
    send_item(mk_item(ACT_INSERT, 0,       '1));
    send_item(mk_item(ACT_INSERT, 3,       '0));
    send_item(mk_item(ACT_INSERT, 2,       32'sh5555_5555));
    send_item(mk_item(ACT_INSERT, 6,       32'sh0F0F_0F0F));
    send_item(mk_item(ACT_INSERT, 5,       32'shAAAA_AAAA));
    send_item(mk_item(ACT_REMOVE, 1,       '1));
    send_item(mk_item(ACT_REMOVE, 0,       '1));
    send_item(mk_item(ACT_REMOVE, 100,     '0));
    send_item(mk_item(ACT_REMOVE, 2,       '0));
    send_item(mk_item(ACT_POP,    MAX_POS, '1));
    send_item(mk_item(ACT_POP,    0,       '0));
    send_item(mk_item(ACT_POP,    0,       '0));
    send_item(mk_item(ACT_REMOVE, LIST_DEPTH, '0));
  endtask

  // Fill to capacity while the receiver holds off, then hit the full cases.
  task automatic test_full_list();
    sender_gaps_on     = 1'b0;
    receiver_stalls_on = 1'b0;
    // Receiver holds off; keep offering so the block backs up into the input.
    long_hold_req = LONG_HOLD;
    while (list_fill < LIST_DEPTH)
      send_item(mk_item(ACT_PUSH, $urandom_range(0, MAX_POS), random_word()));
    receiver_stalls_on = 1'b1;
    send_item(mk_item(ACT_PUSH,   0,              random_word()));
    send_item(mk_item(ACT_INSERT, 0,              random_word()));
    send_item(mk_item(ACT_INSERT, LIST_DEPTH,     random_word()));
    send_item(mk_item(ACT_INSERT, LIST_DEPTH + 1, random_word()));
    send_item(mk_item(ACT_INSERT, MAX_POS,        random_word()));
    send_item(mk_item(ACT_REMOVE, LIST_DEPTH,     '0));
    send_item(mk_item(ACT_INSERT, LIST_DEPTH - 1, random_word()));
    send_item(mk_item(ACT_REMOVE, 0,              '0));
    send_item(mk_item(ACT_INSERT, 0,              random_word()));
    send_item(mk_item(ACT_POP,    0,              '0));
    // Pause the sender until the block has caught up.
    wait_drained();
  endtask

  // Phases that grow, shrink or churn the list, with random idle settings.
  task automatic test_random_mix();
    list_trend_t trend;
    int unsigned r;
    logic [1:0]  act;
    int unsigned pos;
    for (int p = 0; p < RANDOM_ITEMS / PHASE_LEN; p++) begin
      trend              = list_trend_t'($urandom_range(0, 2));
      sender_gaps_on     = ($urandom_range(0, 3) != 0);
      receiver_stalls_on = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PHASE_LEN; n++) begin
        r = $urandom_range(0, 99);
        case (trend)
          TREND_GROW:
            act = (r < 40) ? ACT_PUSH : (r < 75) ? ACT_INSERT :
                  (r < 90) ? ACT_REMOVE : ACT_POP;
          TREND_SHRINK:
            act = (r < 40) ? ACT_POP : (r < 75) ? ACT_REMOVE :
                  (r < 90) ? ACT_INSERT : ACT_PUSH;
          default:
            act = r[1:0];
        endcase
        // Mostly in-range indexes; the rest spans the whole field.
        if ($urandom_range(0, 99) < 15)
          pos = $urandom_range(0, MAX_POS);
        else if (act == ACT_INSERT)
          pos = $urandom_range(0, list_fill);
        else
          pos = (list_fill == 0) ? 0 : $urandom_range(0, list_fill - 1);
        send_item(mk_item(act, pos, random_word()));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Stall the result channel: a requested long hold wins, else random bursts.
  always @(negedge clk) begin
    if (long_hold_req != 0) begin
      stall_left    = long_hold_req;
      long_hold_req = 0;
    end else if (stall_left == 0 && receiver_stalls_on && !rst) begin
      stall_left = random_pause();
    end
    if (stall_left != 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (predicted_summaries.size() == 0) begin
        mismatch_count++;
        $display({"%0t: result with nothing expected: ",
                  "front=%0d back=%0d count=%0d empty=%0b status=%0d"},
                 $time, result.front_value, result.back_value, result.count,
                 result.is_empty, result.status);
      end else begin
        summary_due = predicted_summaries.pop_front();
        if (result !== summary_due) begin
          mismatch_count++;
          $display("%0t: mismatch expected front=%0d back=%0d count=%0d empty=%0b status=%0d",
                   $time, summary_due.front_value, summary_due.back_value,
                   summary_due.count, summary_due.is_empty, summary_due.status);
          $display("%0t:          actual   front=%0d back=%0d count=%0d empty=%0b status=%0d",
                   $time, result.front_value, result.back_value, result.count,
                   result.is_empty, result.status);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence and end of run
  // ---------------------------------------------------------------------------

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_edges();
    test_full_list();
    test_random_mix();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hang guard, several times the slowest legal run.
  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
